// ===== hw/rtl/npwr_pkg.sv =====
package npwr_pkg;

  localparam int unsigned SLOT_W   = 6;
  localparam int unsigned ID_W     = 7;
  localparam int unsigned RAD_W    = 18;
  localparam int unsigned FIELD_W  = 18;
  localparam int unsigned IN_W     = 88;
  localparam int unsigned OUT_W    = 8;

  localparam logic [ID_W-1:0]  ID_MAX         = 7'd64;
  localparam logic [RAD_W-1:0] DEF_RADIUS_RST = 18'd256;

  typedef enum logic [1:0] {
    OP_DECLARE = 2'd0,
    OP_PLACE   = 2'd1,
    OP_QUERY   = 2'd2,
    OP_CLEAR   = 2'd3
  } op_e;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_WALK  = 4'b0010,
    ST_DRAIN = 4'b0100,
    ST_DONE  = 4'b1000
  } state_e;

  typedef struct packed {
    logic run;
    logic used;
    logic first;
    logic last;
  } tag_t;

  typedef struct packed {
    logic            done;
    logic            found;
    logic [ID_W-1:0] id;
  } res_t;

endpackage

// ===== hw/rtl/npwr_dist.sv =====
module npwr_dist #(
  parameter int unsigned COORD_BITS = 18
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  npwr_pkg::tag_t                    tag_i,
  input  logic [npwr_pkg::ID_W-1:0]         id_i,
  input  logic [COORD_BITS-1:0]             sx_i,
  input  logic [COORD_BITS-1:0]             sy_i,
  input  logic [COORD_BITS-1:0]             sz_i,
  input  logic [npwr_pkg::RAD_W-1:0]        rad_i,
  input  logic [COORD_BITS-1:0]             qx_i,
  input  logic [COORD_BITS-1:0]             qy_i,
  input  logic [COORD_BITS-1:0]             qz_i,
  output npwr_pkg::res_t                    res_o
);

  localparam int unsigned CB   = COORD_BITS;
  localparam int unsigned SQW  = 2 * CB;
  localparam int unsigned D2W  = 2 * CB + 2;
  localparam int unsigned R2W  = 2 * npwr_pkg::RAD_W;
  localparam int unsigned CMPW = (D2W > R2W) ? D2W : R2W;

  logic signed [CB:0] dx, dy, dz;
  logic [CB:0]        mx, my, mz;

  npwr_pkg::tag_t              tag1_q, tag2_q, tag3_q;
  logic [npwr_pkg::ID_W-1:0]   id1_q, id2_q, id3_q;
  logic [npwr_pkg::RAD_W-1:0]  rad1_q;
  logic [CB-1:0]               ax_q, ay_q, az_q;
  logic [SQW-1:0]              sqx_q, sqy_q, sqz_q;
  logic [R2W-1:0]              r2_2_q, r2_3_q;
  logic [D2W-1:0]              d2_q;

  logic [D2W-1:0]              best_d2_q;
  logic [npwr_pkg::ID_W-1:0]   best_id_q;
  logic                        have_q;
  logic                        done_q;

  logic have_eff, covered, better, hit;

  assign dx = $signed({sx_i[CB-1], sx_i}) - $signed({qx_i[CB-1], qx_i});
  assign dy = $signed({sy_i[CB-1], sy_i}) - $signed({qy_i[CB-1], qy_i});
  assign dz = $signed({sz_i[CB-1], sz_i}) - $signed({qz_i[CB-1], qz_i});
  assign mx = dx[CB] ? $unsigned(-dx) : $unsigned(dx);
  assign my = dy[CB] ? $unsigned(-dy) : $unsigned(dy);
  assign mz = dz[CB] ? $unsigned(-dz) : $unsigned(dz);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag1_q <= '0;
      tag2_q <= '0;
      tag3_q <= '0;
    end else begin
      tag1_q <= tag_i;
      tag2_q <= tag1_q;
      tag3_q <= tag2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    ax_q   <= mx[CB-1:0];
    ay_q   <= my[CB-1:0];
    az_q   <= mz[CB-1:0];
    rad1_q <= rad_i;
    id1_q  <= id_i;
    sqx_q  <= SQW'(ax_q) * SQW'(ax_q);
    sqy_q  <= SQW'(ay_q) * SQW'(ay_q);
    sqz_q  <= SQW'(az_q) * SQW'(az_q);
    r2_2_q <= R2W'(rad1_q) * R2W'(rad1_q);
    id2_q  <= id1_q;
    d2_q   <= D2W'(sqx_q) + D2W'(sqy_q) + D2W'(sqz_q);
    r2_3_q <= r2_2_q;
    id3_q  <= id2_q;
  end

  assign have_eff = have_q & ~tag3_q.first;
  assign covered  = CMPW'(d2_q) <= CMPW'(r2_3_q);
  assign better   = !have_eff || (d2_q < best_d2_q);
  assign hit      = tag3_q.run && tag3_q.used && covered && better;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      have_q    <= 1'b0;
      best_id_q <= '0;
      done_q    <= 1'b0;
    end else begin
      done_q <= tag3_q.run && tag3_q.last;
      if (hit) begin
        have_q    <= 1'b1;
        best_id_q <= id3_q;
      end else if (tag3_q.run && tag3_q.first) begin
        have_q    <= 1'b0;
        best_id_q <= '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (hit) begin
      best_d2_q <= d2_q;
    end
  end

  assign res_o.done  = done_q;
  assign res_o.found = have_q;
  assign res_o.id    = best_id_q;

endmodule

// ===== hw/rtl/nearest_point_within_radius_core.sv =====
// Nearest covering point over a table of TABLE_SLOTS slots.
// Input beats arrive on s_axis; each carries one operation: declare a slot,
// place a declared slot, query the nearest covering point, or clear the table.
// Declare, place and clear complete in the cycle their beat is accepted and
// produce no output beat. A query walks every slot, one slot per cycle, through
// one pipelined squared-distance unit, and produces one beat on m_axis.
// A query keeps s_axis_tready low from its accepted beat until its answer is
// loaded into the output register, so no beat is taken during the walk.
// Other operations leave the block idle and ready for the next beat.
// The output beat sits in a register; when the receiver stalls, the block
// still takes declare, place and clear beats and starts the next query, and
// holds that query's answer until the pending beat has been taken.
// The default radius is written through cfg_we_i and cfg_wdata_i; the user must
// write it only while idle, as the block does not enforce this. Reset empties
// the table, sets the default radius to 256 and is ready with no clearing pass.
module nearest_point_within_radius_core #(
  parameter int unsigned TABLE_SLOTS = 64,
  parameter int unsigned COORD_BITS  = 18
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [npwr_pkg::RAD_W-1:0]        cfg_wdata_i,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // opcode[1:0], slot[7:2], entry_id[14:8], pos_x[32:15], pos_y[50:33],
  // pos_z[68:51], reach[86:69], zero[87].
  input  logic [npwr_pkg::IN_W-1:0]         s_axis_tdata,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // nearest_id[6:0], found[7].
  output logic [npwr_pkg::OUT_W-1:0]        m_axis_tdata
);

  localparam int unsigned CB   = COORD_BITS;
  localparam int unsigned AW   = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
  localparam int unsigned SXW  = (AW + 1 > npwr_pkg::SLOT_W) ? AW + 1 : npwr_pkg::SLOT_W;
  localparam int unsigned XW   = (CB > npwr_pkg::FIELD_W) ? CB : npwr_pkg::FIELD_W;
  localparam int unsigned PW   = 3 * CB;

  npwr_pkg::state_e state_q, state_d;

  logic [npwr_pkg::RAD_W-1:0] def_rad_q;
  logic [TABLE_SLOTS-1:0]     declared_q, placed_q;

  logic [npwr_pkg::ID_W-1:0]  id_mem  [TABLE_SLOTS];
  logic [PW-1:0]              pos_mem [TABLE_SLOTS];
  logic [npwr_pkg::RAD_W-1:0] rad_mem [TABLE_SLOTS];

  logic [AW-1:0]              cnt_q;
  logic [CB-1:0]              qx_q, qy_q, qz_q;

  npwr_pkg::tag_t             tag0_q, tag0_d;
  logic [npwr_pkg::ID_W-1:0]  rd_id_q;
  logic [PW-1:0]              rd_pos_q;
  logic [npwr_pkg::RAD_W-1:0] rd_rad_q;

  logic                       out_valid_q;
  logic [npwr_pkg::ID_W-1:0]  out_id_q;
  logic                       out_found_q;

  npwr_pkg::res_t             res;

  npwr_pkg::op_e              in_op;
  logic [SXW-1:0]             in_slot;
  logic [AW-1:0]              waddr;
  logic                       slot_ok;
  logic [npwr_pkg::ID_W-1:0]  in_id;
  logic [XW-1:0]              in_x, in_y, in_z;
  logic [npwr_pkg::RAD_W-1:0] in_reach, place_rad;
  logic                       in_acc, decl_we, place_we, clear_we, query_go;
  logic                       walking, walk_last, out_load;

  assign in_op    = npwr_pkg::op_e'(s_axis_tdata[1:0]);
  assign in_slot  = SXW'(s_axis_tdata[7:2]);
  assign waddr    = in_slot[AW-1:0];
  assign slot_ok  = in_slot < SXW'(TABLE_SLOTS);
  assign in_id    = s_axis_tdata[14:8];
  assign in_x     = XW'(s_axis_tdata[32:15]);
  assign in_y     = XW'(s_axis_tdata[50:33]);
  assign in_z     = XW'(s_axis_tdata[68:51]);
  assign in_reach = s_axis_tdata[86:69];
  assign place_rad = (in_reach != '0) ? in_reach : def_rad_q;

  assign s_axis_tready = (state_q == npwr_pkg::ST_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  always_comb begin
    decl_we  = 1'b0;
    place_we = 1'b0;
    clear_we = 1'b0;
    query_go = 1'b0;
    if (in_acc) begin
      unique case (in_op)
        npwr_pkg::OP_DECLARE: decl_we  = slot_ok && (in_id <= npwr_pkg::ID_MAX);
        npwr_pkg::OP_PLACE:   place_we = slot_ok && declared_q[waddr];
        npwr_pkg::OP_QUERY:   query_go = 1'b1;
        npwr_pkg::OP_CLEAR:   clear_we = 1'b1;
        default:              clear_we = 1'b0;
      endcase
    end
  end

  assign walking   = (state_q == npwr_pkg::ST_WALK);
  assign walk_last = (cnt_q == AW'(TABLE_SLOTS - 1));
  assign out_load  = (state_q == npwr_pkg::ST_DONE) && (!out_valid_q || m_axis_tready);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      npwr_pkg::ST_IDLE:  if (query_go) state_d = npwr_pkg::ST_WALK;
      npwr_pkg::ST_WALK:  if (walk_last) state_d = npwr_pkg::ST_DRAIN;
      npwr_pkg::ST_DRAIN: if (res.done) state_d = npwr_pkg::ST_DONE;
      npwr_pkg::ST_DONE:  if (out_load) state_d = npwr_pkg::ST_IDLE;
      default:            state_d = npwr_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    tag0_d       = '0;
    tag0_d.run   = walking;
    tag0_d.used  = walking && placed_q[cnt_q];
    tag0_d.first = walking && (cnt_q == '0);
    tag0_d.last  = walking && walk_last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= npwr_pkg::ST_IDLE;
      def_rad_q   <= npwr_pkg::DEF_RADIUS_RST;
      declared_q  <= '0;
      placed_q    <= '0;
      cnt_q       <= '0;
      tag0_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      tag0_q  <= tag0_d;
      if (cfg_we_i) begin
        def_rad_q <= cfg_wdata_i;
      end
      if (clear_we) begin
        declared_q <= '0;
        placed_q   <= '0;
      end else if (decl_we) begin
        declared_q[waddr] <= (in_id != '0);
        placed_q[waddr]   <= 1'b0;
      end else if (place_we) begin
        placed_q[waddr] <= 1'b1;
      end
      if (query_go) begin
        cnt_q <= '0;
      end else if (walking) begin
        cnt_q <= cnt_q + AW'(1);
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (decl_we) begin
      id_mem[waddr]  <= in_id;
      rad_mem[waddr] <= def_rad_q;
    end
    if (place_we) begin
      pos_mem[waddr] <= {in_z[CB-1:0], in_y[CB-1:0], in_x[CB-1:0]};
      rad_mem[waddr] <= place_rad;
    end
    if (walking) begin
      rd_id_q  <= id_mem[cnt_q];
      rd_pos_q <= pos_mem[cnt_q];
      rd_rad_q <= rad_mem[cnt_q];
    end
    if (query_go) begin
      qx_q <= in_x[CB-1:0];
      qy_q <= in_y[CB-1:0];
      qz_q <= in_z[CB-1:0];
    end
    if (out_load) begin
      out_id_q    <= res.id;
      out_found_q <= res.found;
    end
  end

  npwr_dist #(
    .COORD_BITS(COORD_BITS)
  ) u_dist (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .tag_i  (tag0_q),
    .id_i   (rd_id_q),
    .sx_i   (rd_pos_q[CB-1:0]),
    .sy_i   (rd_pos_q[2*CB-1:CB]),
    .sz_i   (rd_pos_q[3*CB-1:2*CB]),
    .rad_i  (rd_rad_q),
    .qx_i   (qx_q),
    .qy_i   (qy_q),
    .qz_i   (qz_q),
    .res_o  (res)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_found_q, out_id_q};

  a_placed_declared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (placed_q & ~declared_q) == '0)
    else $error("placed slot is not declared");

  a_found_id: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_found_q == (out_id_q != '0)))
    else $error("found flag disagrees with id");

  a_done_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res.done |-> (state_q == npwr_pkg::ST_DRAIN))
    else $error("distance unit finished outside drain");

  a_hold_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == npwr_pkg::ST_DONE && out_valid_q && !m_axis_tready)
      |=> (state_q == npwr_pkg::ST_DONE && $stable(m_axis_tdata)))
    else $error("pending output beat overwritten");

endmodule

// ===== tb/tb_top.sv =====
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned FIELD_W       = npwr_pkg::FIELD_W;
  localparam int unsigned RAD_W         = npwr_pkg::RAD_W;
  localparam int unsigned ID_W          = npwr_pkg::ID_W;
  localparam int unsigned SLOT_W        = npwr_pkg::SLOT_W;
  localparam int unsigned IN_W          = npwr_pkg::IN_W;
  localparam int unsigned OUT_W         = npwr_pkg::OUT_W;
  localparam logic [ID_W-1:0] ID_MAX    = npwr_pkg::ID_MAX;

  localparam int unsigned SLOTS         = 64;
  localparam int unsigned QUERY_LATENCY = SLOTS + 6;
  localparam int unsigned SETTLE_CYCLES = QUERY_LATENCY + 10;
  localparam int unsigned CYCLE_LIMIT   = 600000;
  localparam int unsigned PHASE_ITEMS   = 150;

  typedef logic signed [FIELD_W-1:0] coord_t;

  localparam coord_t           COORD_MIN = {1'b1, {(FIELD_W-1){1'b0}}};
  localparam coord_t           COORD_MAX = {1'b0, {(FIELD_W-1){1'b1}}};
  localparam logic [RAD_W-1:0] RAD_MAX   = {RAD_W{1'b1}};

  typedef struct packed {
    logic              pad;
    logic [RAD_W-1:0]  reach;
    coord_t            pos_z;
    coord_t            pos_y;
    coord_t            pos_x;
    logic [ID_W-1:0]   entry_id;
    logic [SLOT_W-1:0] slot;
    npwr_pkg::op_e     opcode;
  } cmd_beat_t;

  typedef struct packed {
    logic            found;
    logic [ID_W-1:0] nearest_id;
  } answer_t;

  typedef struct {
    logic [ID_W-1:0]  id;
    coord_t           x;
    coord_t           y;
    coord_t           z;
    logic [RAD_W-1:0] radius;
    logic             placed;
  } slot_entry_t;

  class nearest_scoreboard;
    slot_entry_t      entries[SLOTS];
    logic [RAD_W-1:0] default_radius;
    answer_t          pending_answers[$];
    int               beats;
    int               queries;
    int               hits;
    int               errors;

    function new();
      default_radius = npwr_pkg::DEF_RADIUS_RST;
      beats   = 0;
      queries = 0;
      hits    = 0;
      errors  = 0;
      clear_slots();
    endfunction

    function void clear_slots();
      foreach (entries[i]) begin
        entries[i].id     = '0;
        entries[i].x      = '0;
        entries[i].y      = '0;
        entries[i].z      = '0;
        entries[i].radius = '0;
        entries[i].placed = 1'b0;
      end
    endfunction

    function void set_default_radius(logic [RAD_W-1:0] value);
      default_radius = value;
    endfunction

    function int pending();
      return pending_answers.size();
    endfunction

    function void note_beat(logic [IN_W-1:0] raw);
      cmd_beat_t cmd;
      answer_t   best;
      longint    dx;
      longint    dy;
      longint    dz;
      longint    d2;
      longint    r2;
      longint    best_d2;
      cmd = cmd_beat_t'(raw);
      beats++;
      case (cmd.opcode)
        npwr_pkg::OP_DECLARE: begin
          if (cmd.entry_id <= ID_MAX) begin
            entries[cmd.slot].id     = cmd.entry_id;
            entries[cmd.slot].radius = default_radius;
            entries[cmd.slot].placed = 1'b0;
          end
        end
        npwr_pkg::OP_PLACE: begin
          if (entries[cmd.slot].id != '0) begin
            entries[cmd.slot].x      = cmd.pos_x;
            entries[cmd.slot].y      = cmd.pos_y;
            entries[cmd.slot].z      = cmd.pos_z;
            entries[cmd.slot].radius = (cmd.reach != '0) ? cmd.reach : default_radius;
            entries[cmd.slot].placed = 1'b1;
          end
        end
        npwr_pkg::OP_CLEAR: begin
          clear_slots();
        end
        default: begin
          best    = '0;
          best_d2 = 0;
          foreach (entries[i]) begin
            if (entries[i].placed && entries[i].id != '0) begin
              dx = longint'(cmd.pos_x) - longint'(entries[i].x);
              dy = longint'(cmd.pos_y) - longint'(entries[i].y);
              dz = longint'(cmd.pos_z) - longint'(entries[i].z);
              d2 = dx * dx + dy * dy + dz * dz;
              r2 = longint'(entries[i].radius) * longint'(entries[i].radius);
              if (d2 <= r2 && (!best.found || d2 < best_d2)) begin
                best.found      = 1'b1;
                best.nearest_id = entries[i].id;
                best_d2         = d2;
              end
            end
          end
          queries++;
          if (best.found) begin
            hits++;
          end
          pending_answers.push_back(best);
        end
      endcase
    endfunction

    function void check_answer(logic [OUT_W-1:0] raw);
      answer_t got;
      answer_t want;
      got = answer_t'(raw);
      if (pending_answers.size() == 0) begin
        $error("Output beat with no query waiting: nearest_id %0d found %0d",
               got.nearest_id, got.found);
        errors++;
        return;
      end
      want = pending_answers.pop_front();
      if (got.nearest_id !== want.nearest_id) begin
        $error("nearest_id mismatch: expected %0d, actual %0d", want.nearest_id, got.nearest_id);
        errors++;
      end
      if (got.found !== want.found) begin
        $error("found mismatch: expected %0d, actual %0d", want.found, got.found);
        errors++;
      end
    endfunction
  endclass

  logic              clk_i         = 1'b0;
  logic              rst_ni        = 1'b0;
  logic              cfg_we_i      = 1'b0;
  logic [RAD_W-1:0]  cfg_wdata_i   = '0;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [IN_W-1:0]   s_axis_tdata  = '0;
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [OUT_W-1:0]  m_axis_tdata;

  nearest_scoreboard nearest_sb;
  int                send_idle_pct   = 0;
  int                recv_idle_pct   = 0;
  int                radius_settings = 0;
  int                cycle_count     = 0;
  logic [SLOTS-1:0]  declared_hint   = '0;
  bit signed [FIELD_W-1:0] aim_x[SLOTS];
  bit signed [FIELD_W-1:0] aim_y[SLOTS];
  bit signed [FIELD_W-1:0] aim_z[SLOTS];

  nearest_point_within_radius_core #(
    .TABLE_SLOTS(SLOTS),
    .COORD_BITS (FIELD_W)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_we_i) begin
        nearest_sb.set_default_radius(cfg_wdata_i);
      end
      if (s_axis_tvalid && s_axis_tready) begin
        nearest_sb.note_beat(s_axis_tdata);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        nearest_sb.check_answer(m_axis_tdata);
      end
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("FAILED: results differ");
    $finish;
  end

  function automatic coord_t rand_coord();
    int pick;
    pick = $urandom_range(99);
    if (pick < 8) begin
      return (pick < 4) ? COORD_MIN : COORD_MAX;
    end
    if (pick < 25) begin
      return coord_t'($urandom);
    end
    return coord_t'(int'($urandom_range(1200)) - 600);
  endfunction

  function automatic int query_offset(bit exact);
    if (exact) begin
      return 0;
    end
    return int'($urandom_range(800)) - 400;
  endfunction

  task automatic send_beat(cmd_beat_t cmd);
    int gap;
    gap = 0;
    while (gap < 40 && $urandom_range(99) < send_idle_pct) begin
      gap++;
    end
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= cmd;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic send_cmd(npwr_pkg::op_e op, int slot, int id, int x, int y, int z, int reach);
    cmd_beat_t cmd;
    cmd          = '0;
    cmd.opcode   = op;
    cmd.slot     = SLOT_W'(slot);
    cmd.entry_id = ID_W'(id);
    cmd.pos_x    = coord_t'(x);
    cmd.pos_y    = coord_t'(y);
    cmd.pos_z    = coord_t'(z);
    cmd.reach    = RAD_W'(reach);
    send_beat(cmd);
  endtask

  task automatic send_random_cmd();
    cmd_beat_t cmd;
    int        pick;
    int        tries;
    int        aim;
    bit        exact;
    cmd          = '0;
    cmd.slot     = SLOT_W'($urandom_range(SLOTS - 1));
    cmd.entry_id = ID_W'($urandom_range(ID_MAX));
    cmd.pos_x    = rand_coord();
    cmd.pos_y    = rand_coord();
    cmd.pos_z    = rand_coord();
    cmd.reach    = RAD_W'($urandom);
    pick = $urandom_range(99);
    if (pick < 22) begin
      cmd.opcode = npwr_pkg::OP_DECLARE;
      pick = $urandom_range(99);
      if (pick < 5) begin
        cmd.entry_id = '0;
      end else if (pick < 15) begin
        cmd.entry_id = ID_MAX;
      end else begin
        cmd.entry_id = ID_W'($urandom_range(ID_MAX, 1));
      end
      declared_hint[cmd.slot] = (cmd.entry_id != '0);
    end else if (pick < 55) begin
      cmd.opcode = npwr_pkg::OP_PLACE;
      tries = 0;
      while (tries < 8 && !declared_hint[cmd.slot]) begin
        cmd.slot = SLOT_W'($urandom_range(SLOTS - 1));
        tries++;
      end
      pick = $urandom_range(99);
      if (pick < 30) begin
        cmd.reach = '0;
      end else if (pick < 75) begin
        cmd.reach = RAD_W'($urandom_range(1500, 1));
      end
      aim_x[cmd.slot] = cmd.pos_x;
      aim_y[cmd.slot] = cmd.pos_y;
      aim_z[cmd.slot] = cmd.pos_z;
    end else if (pick < 98) begin
      cmd.opcode = npwr_pkg::OP_QUERY;
      pick = $urandom_range(99);
      if (pick < 60) begin
        aim   = $urandom_range(SLOTS - 1);
        exact = (pick < 12);
        cmd.pos_x = coord_t'(int'(aim_x[aim]) + query_offset(exact));
        cmd.pos_y = coord_t'(int'(aim_y[aim]) + query_offset(exact));
        cmd.pos_z = coord_t'(int'(aim_z[aim]) + query_offset(exact));
      end
    end else begin
      cmd.opcode    = npwr_pkg::OP_CLEAR;
      declared_hint = '0;
    end
    send_beat(cmd);
  endtask

  task automatic wait_for_answers();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (nearest_sb.pending() != 0) begin
      @(posedge clk_i);
    end
  endtask

  task automatic write_default_radius(logic [RAD_W-1:0] value);
    wait_for_answers();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    radius_settings++;
  endtask

  initial begin
    nearest_sb = new();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed checks with the reset default radius of 256.
    send_cmd(npwr_pkg::OP_QUERY, 0, 0, 0, 0, 0, 0);
    send_cmd(npwr_pkg::OP_DECLARE, 0, 5, 0, 0, 0, 0);
    send_cmd(npwr_pkg::OP_PLACE, 1, 0, 0, 0, 0, 0);
    send_cmd(npwr_pkg::OP_QUERY, 0, 0, 0, 0, 0, 0);
    send_cmd(npwr_pkg::OP_PLACE, 0, 0, 100, -100, 50, 0);
    send_cmd(npwr_pkg::OP_QUERY, 0, 0, 100, -100, 306, 0);
    send_cmd(npwr_pkg::OP_QUERY, 0, 0, 100, -100, 307, 0);
    send_cmd(npwr_pkg::OP_DECLARE, SLOTS - 1, ID_MAX, 0, 0, 0, 0);
    send_cmd(npwr_pkg::OP_PLACE, SLOTS - 1, 0, COORD_MIN, COORD_MIN, COORD_MIN, RAD_MAX);
    send_cmd(npwr_pkg::OP_DECLARE, 2, 7, 0, 0, 0, 0);
    send_cmd(npwr_pkg::OP_PLACE, 2, 0, COORD_MAX, COORD_MAX, COORD_MAX, RAD_MAX);
    send_cmd(npwr_pkg::OP_QUERY, 0, 0, COORD_MIN, COORD_MIN, COORD_MIN, 0);
    send_cmd(npwr_pkg::OP_QUERY, 0, 0, COORD_MAX, COORD_MAX, COORD_MAX, 0);
    send_cmd(npwr_pkg::OP_DECLARE, 3, 9, 0, 0, 0, 0);
    send_cmd(npwr_pkg::OP_PLACE, 3, 0, 100, -100, 50, 300);
    send_cmd(npwr_pkg::OP_DECLARE, 4, 5, 0, 0, 0, 0);
    send_cmd(npwr_pkg::OP_QUERY, 0, 0, 100, -100, 60, 0);
    send_cmd(npwr_pkg::OP_DECLARE, 0, int'(ID_MAX) + 1, 0, 0, 0, 0);
    send_cmd(npwr_pkg::OP_DECLARE, 3, 0, 0, 0, 0, 0);
    send_cmd(npwr_pkg::OP_QUERY, 0, 0, 100, -100, 60, 0);
    send_cmd(npwr_pkg::OP_CLEAR, 0, 0, 0, 0, 0, 0);
    send_cmd(npwr_pkg::OP_QUERY, 0, 0, 100, -100, 50, 0);

    // A zero default radius covers only the exact placed point.
    write_default_radius('0);
    send_cmd(npwr_pkg::OP_DECLARE, 0, 1, 0, 0, 0, 0);
    send_cmd(npwr_pkg::OP_PLACE, 0, 0, 5, 5, 5, 0);
    send_cmd(npwr_pkg::OP_QUERY, 0, 0, 5, 5, 5, 0);
    send_cmd(npwr_pkg::OP_QUERY, 0, 0, 5, 5, 6, 0);

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 15;
          recv_idle_pct = 81;
          write_default_radius(RAD_MAX);
        end
        1: begin
          send_idle_pct = 81;
          recv_idle_pct = 15;
          write_default_radius(RAD_W'(1));
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
          write_default_radius(RAD_W'($urandom_range(RAD_MAX, 1)));
        end
      endcase
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (phase == 0 && n == PHASE_ITEMS / 2) begin
          wait_for_answers();
        end
        send_random_cmd();
      end
    end

    wait_for_answers();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    $display("Run covered %0d input beats and %0d queries, %0d of which found a point,",
             nearest_sb.beats, nearest_sb.queries, nearest_sb.hits);
    $display("over %0d default radius settings and three stall patterns.", radius_settings);
    if (nearest_sb.errors == 0 && nearest_sb.pending() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
